// ----- sv/mos_pkg.sv -----
// ----------------------------------------------------------------------------
// Mahalanobis outlier score package
// Shared widths, register indexes, stage latencies and lane mapping helpers.
// ----------------------------------------------------------------------------
package mos_pkg;

   localparam int DEF_CHANNELS    = 3;
   localparam int DEF_SAMPLE_BITS = 16;
   localparam int MAX_CH          = 3;
   localparam int MAX_LANES       = 6;

   localparam int SAMPLE_W = 16;
   localparam int DIFF_W   = 17;
   localparam int COEF_W   = 18;
   localparam int PROD_W   = 34;
   localparam int TERM_W   = 56;
   localparam int DIST_W   = 40;
   localparam int ROOT_W   = 20;
   localparam int PRIOR_W  = 17;
   localparam int SCORE_W  = 20;
   localparam int CFG_W    = 54;
   localparam int IDX_W    = 3;

   localparam int LANE_LAT  = 3;
   localparam int MERGE_LAT = 4;
   localparam int SQRT_LAT  = ROOT_W;

   localparam logic [IDX_W-1:0] REG_MEAN     = 3'd0;
   localparam logic [IDX_W-1:0] REG_DIAG     = 3'd1;
   localparam logic [IDX_W-1:0] REG_OFFDIAG  = 3'd2;
   localparam logic [IDX_W-1:0] REG_SHIFT    = 3'd3;
   localparam logic [IDX_W-1:0] REG_BOUND    = 3'd4;
   localparam logic [IDX_W-1:0] REG_T1       = 3'd5;

   localparam logic [5:0]          SHIFT_RESET = 6'd16;
   localparam logic [SAMPLE_W-1:0] BOUND_RESET = 16'hFFFF;

   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [TERM_W-1:0] term_type;

   typedef struct packed {
      logic               gate;
      logic [PRIOR_W-1:0] prior;
   } side_type;

   // Lane l covers the matrix entry (lane_row(l), lane_col(l)) with row <= col.
   function automatic int lane_row(input int l);
      int r;
      r = (l < 3) ? 0 : ((l < 5) ? 1 : 2);
      return r;
   endfunction

   function automatic int lane_col(input int l);
      int c;
      case (l)
         0: c = 0;
         1: c = 1;
         2: c = 2;
         3: c = 1;
         4: c = 2;
         default: c = 2;
      endcase
      return c;
   endfunction

endpackage

// ----- sv/mahalanobis_outlier_score.sv -----
// ----------------------------------------------------------------------------
// Mahalanobis outlier score
// Squared Mahalanobis distance of a three channel voxel and its gated score.
// ----------------------------------------------------------------------------
// Channel  Direction  Fields (lowest bit first)
// req      in         chan_zero, chan_one, chan_two, prior_weight
// rsp      out        distance_sq, score, gate_passed
// csr      in         write enable, register index, write data
//
// One item enters per cycle while no result is stalled; each item's result
// passes through 30 register stages, most of them the 20 stage square root
// pipeline. Reset sets the configuration registers to their defaults and
// clears the valid line; the data path is not reset. A stalled result holds
// the whole pipeline, so req_tready follows rsp_tready while a result is waiting.
// ----------------------------------------------------------------------------
module mahalanobis_outlier_score
   import mos_pkg::*;
#(
   parameter int CHANNELS    = DEF_CHANNELS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [71:0]      req_tdata,   // chan_zero, chan_one, chan_two, prior_weight
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [63:0]      rsp_tdata,   // distance_sq, score, gate_passed
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   localparam int USED = (CHANNELS < MAX_CH) ? CHANNELS : MAX_CH;
   localparam logic [SAMPLE_W-1:0] SMASK = SAMPLE_W'((17'd1 << SAMPLE_BITS) - 17'd1);
   localparam int DEPTH = 1 + LANE_LAT + MERGE_LAT + SQRT_LAT + 1;

   logic [47:0]         mean_ff;
   logic [CFG_W-1:0]    diag_ff, offdiag_ff;
   logic [5:0]          shift_ff;
   logic [SAMPLE_W-1:0] bound_ff;
   logic                t1_ff;

   logic                en, req_accept;
   logic [DEPTH-1:0]    vld_ff, vld_in;
   diff_type            d_ff [MAX_CH];
   diff_type            d_in [MAX_CH];
   side_type            side_in0;
   side_type            side_dly_ff [LANE_LAT+MERGE_LAT+1];
   term_type            terms [MAX_LANES];
   logic [DIST_W-1:0]   m_dist, sq_dist;
   logic [ROOT_W-1:0]   sq_root;
   side_type            sq_side;
   logic [ROOT_W+PRIOR_W-1:0] prod_ff;
   logic [DIST_W-1:0]   pdist_ff;
   logic                pgate_ff;
   logic [DIST_W-1:0]   odist_ff;
   logic [SCORE_W-1:0]  oscore_ff, oscore_in;
   logic                ogate_ff;
   logic                rsp_tvalid_ff;
   logic [ROOT_W+PRIOR_W-17:0] prod_hi;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;
   assign req_accept = req_tvalid && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff    <= '0;
         diag_ff    <= '0;
         offdiag_ff <= '0;
         shift_ff   <= SHIFT_RESET;
         bound_ff   <= BOUND_RESET;
         t1_ff      <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_MEAN:    mean_ff    <= csr_wdata[47:0];
            REG_DIAG:    diag_ff    <= csr_wdata;
            REG_OFFDIAG: offdiag_ff <= csr_wdata;
            REG_SHIFT:   shift_ff   <= csr_wdata[5:0];
            REG_BOUND:   bound_ff   <= csr_wdata[SAMPLE_W-1:0];
            REG_T1:      t1_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [SAMPLE_W-1:0] x, m;
      side_in0.gate  = 1'b1;
      side_in0.prior = req_tdata[64:48];
      for (int i = 0; i < MAX_CH; i++) begin
         x = req_tdata[SAMPLE_W*i +: SAMPLE_W] & SMASK;
         m = mean_ff[SAMPLE_W*i +: SAMPLE_W] & SMASK;
         d_in[i] = '0;
         if (i < USED) begin
            d_in[i] = $signed({1'b0, m}) - $signed({1'b0, x});
            if (t1_ff && i == USED - 1) begin
               if (x > bound_ff) side_in0.gate = 1'b0;
            end else if (x < m) begin
               side_in0.gate = 1'b0;
            end
         end
      end
   end

   assign vld_in = {vld_ff[DEPTH-2:0], req_accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         vld_ff        <= vld_in;
         rsp_tvalid_ff <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff           <= d_in;
         side_dly_ff[0] <= side_in0;
         for (int k = 1; k < LANE_LAT + MERGE_LAT + 1; k++) begin
            side_dly_ff[k] <= side_dly_ff[k-1];
         end
      end
   end

   for (genvar l = 0; l < MAX_LANES; l++) begin : g_lane
      localparam int LR = lane_row(l);
      localparam int LC = lane_col(l);
      if (LC < USED) begin : g_on
         coef_type coef;
         if (LR == LC) begin : g_diag
            assign coef = diag_ff[COEF_W*LR +: COEF_W];
         end else begin : g_off
            assign coef = offdiag_ff[COEF_W*(LR+LC-1) +: COEF_W];
         end
         mos_lane #(.DOUBLE(LR != LC)) u_lane (
            .clock (clock),
            .en    (en),
            .d_a   (d_ff[LR]),
            .d_b   (d_ff[LC]),
            .coef  (coef),
            .term  (terms[l])
         );
      end else begin : g_off_lane
         assign terms[l] = '0;
      end
   end

   mos_merge u_merge (
      .clock  (clock),
      .en     (en),
      .terms  (terms),
      .shift  (shift_ff),
      .dist_q (m_dist)
   );

   mos_sqrt u_sqrt (
      .clock    (clock),
      .en       (en),
      .dist_in  (m_dist),
      .side_in  (side_dly_ff[LANE_LAT+MERGE_LAT]),
      .root     (sq_root),
      .dist_out (sq_dist),
      .side_out (sq_side)
   );

   assign prod_hi = prod_ff[ROOT_W+PRIOR_W-1:16];

   always_comb begin
      if (!pgate_ff) begin
         oscore_in = '0;
      end else if (prod_hi[ROOT_W+PRIOR_W-17]) begin
         oscore_in = '1;
      end else begin
         oscore_in = prod_hi[SCORE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= (ROOT_W+PRIOR_W)'(sq_root) * (ROOT_W+PRIOR_W)'(sq_side.prior);
         pdist_ff  <= sq_dist;
         pgate_ff  <= sq_side.gate;
         odist_ff  <= pdist_ff;
         oscore_ff <= oscore_in;
         ogate_ff  <= pgate_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {3'b000, ogate_ff, oscore_ff, odist_ff};

`ifndef SYNTH
   a_gate_score: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !ogate_ff |-> oscore_ff == '0)
      else $error("score nonzero with failed gate");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_root_low: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DEPTH-2] |-> (42'(sq_root) * 42'(sq_root)) <= 42'(sq_dist))
      else $error("square root too large");

   a_root_high: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DEPTH-2] |-> ((42'(sq_root) + 42'd1) * (42'(sq_root) + 42'd1)) > 42'(sq_dist))
      else $error("square root too small");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted item missing from pipeline");
`endif

endmodule

// ----- sv/mos_lane.sv -----
// ----------------------------------------------------------------------------
// Mahalanobis lane
// One term coef * d_a * d_b of the quadratic form, doubled when DOUBLE is set, over three stages.
// ----------------------------------------------------------------------------
module mos_lane
   import mos_pkg::*;
#(
   parameter bit DOUBLE = 1'b0
) (
   input  logic     clock,
   input  logic     en,
   input  diff_type d_a,
   input  diff_type d_b,
   input  coef_type coef,
   output term_type term
);

   logic signed [PROD_W-1:0]   p_ff, p_in;
   logic signed [COEF_W+17:0]  lo_ff, lo_in;
   logic signed [COEF_W+16:0]  hi_ff, hi_in;
   term_type                   term_ff, term_in, sum;

   assign p_in  = d_a * d_b;
   assign lo_in = coef * $signed({1'b0, p_ff[16:0]});
   assign hi_in = coef * $signed(p_ff[PROD_W-1:17]);
   assign sum   = (TERM_W'(hi_ff) <<< 17) + TERM_W'(lo_ff);
   assign term_in = DOUBLE ? (sum <<< 1) : sum;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff    <= p_in;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule

// ----- sv/mos_merge.sv -----
// ----------------------------------------------------------------------------
// Mahalanobis merge
// Registered adder tree over the lane terms, then clamp, shift and saturate.
// ----------------------------------------------------------------------------
module mos_merge
   import mos_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  term_type          terms [MAX_LANES],
   input  logic [5:0]        shift,
   output logic [DIST_W-1:0] dist_q
);

   localparam logic [TERM_W-1:0] DIST_MAX = TERM_W'((64'd1 << DIST_W) - 64'd1);

   term_type          s1_ff [3];
   term_type          s2_ff, s2b_ff, q_ff;
   logic [TERM_W-1:0] shr;
   logic [DIST_W-1:0] dist_ff, dist_in;

   assign shr = TERM_W'(q_ff) >> shift;

   always_comb begin
      if (q_ff <= 0) begin
         dist_in = '0;
      end else if (shr > DIST_MAX) begin
         dist_in = '1;
      end else begin
         dist_in = shr[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff[0] <= terms[0] + terms[1];
         s1_ff[1] <= terms[2] + terms[3];
         s1_ff[2] <= terms[4] + terms[5];
         s2_ff    <= s1_ff[0] + s1_ff[1];
         s2b_ff   <= s1_ff[2];
         q_ff     <= s2_ff + s2b_ff;
         dist_ff  <= dist_in;
      end
   end

   assign dist_q = dist_ff;

endmodule

// ----- sv/mos_sqrt.sv -----
// ----------------------------------------------------------------------------
// Mahalanobis square root
// Pipelined restoring integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module mos_sqrt
   import mos_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [DIST_W-1:0] dist_in,
   input  side_type          side_in,
   output logic [ROOT_W-1:0] root,
   output logic [DIST_W-1:0] dist_out,
   output side_type          side_out
);

   localparam int REM_W = ROOT_W + 4;

   logic [REM_W-1:0]  rem_ff  [SQRT_LAT];
   logic [ROOT_W-1:0] root_ff [SQRT_LAT];
   logic [DIST_W-1:0] rad_ff  [SQRT_LAT];
   logic [DIST_W-1:0] dist_ff [SQRT_LAT];
   side_type          side_ff [SQRT_LAT];

   for (genvar k = 0; k < SQRT_LAT; k++) begin : g_step
      logic [REM_W-1:0]  rem_p, trial, tst, rem_in;
      logic [ROOT_W-1:0] root_p, root_in;
      logic [DIST_W-1:0] rad_p, dist_p;
      side_type          side_p;

      if (k == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = dist_in;
         assign dist_p = dist_in;
         assign side_p = side_in;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign rad_p  = rad_ff[k-1];
         assign dist_p = dist_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      assign trial = {rem_p[REM_W-3:0], rad_p[DIST_W-1 -: 2]};
      assign tst   = {{(REM_W-ROOT_W-2){1'b0}}, root_p, 2'b01};

      always_comb begin
         if (trial >= tst) begin
            rem_in  = trial - tst;
            root_in = {root_p[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            root_in = {root_p[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_p << 2;
            dist_ff[k] <= dist_p;
            side_ff[k] <= side_p;
         end
      end
   end

   assign root     = root_ff[SQRT_LAT-1];
   assign dist_out = dist_ff[SQRT_LAT-1];
   assign side_out = side_ff[SQRT_LAT-1];

endmodule

// ----- verif/mos_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mahalanobis outlier score checker
// Watches the request, result and register channels, predicts each result
// from the accepted item and the current registers, and compares in order.
// ----------------------------------------------------------------------------
module mos_checker
   import mos_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [71:0]      req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [63:0]      rsp_tdata,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0] csr_wdata,
   output int               fail_count,
   output int               pending_count
);

   typedef struct packed {
      logic [DIST_W-1:0]  dist_sq;
      logic [SCORE_W-1:0] score;
      logic               gate;
   } score_type;

   logic [47:0] mean_ff;
   logic [53:0] diag_ff;
   logic [53:0] offdiag_ff;
   logic [5:0]  shift_ff;
   logic [15:0] bound_ff;
   logic        t1_ff;
   score_type   expected_scores[$];

   function automatic logic signed [63:0] coef_at(input logic [53:0] packed_v, input int slot);
      logic signed [17:0] c;
      c = packed_v[18*slot +: 18];
      return 64'(c);
   endfunction

   function automatic logic [19:0] root_of(input logic [39:0] v);
      logic [39:0] r;
      r = 0;
      for (int b = 19; b >= 0; b--) begin
         logic [39:0] t;
         t = r | (40'd1 << b);
         if (t * t <= v) r = t;
      end
      return r[19:0];
   endfunction

   function automatic score_type predict_score(input logic [71:0] d_in);
      logic signed [63:0] dv[3];
      logic signed [63:0] q;
      logic [15:0]        x, m;
      logic [63:0]        dist_v, sc;
      score_type          res;
      logic               g;
      g = 1'b1;
      for (int i = 0; i < 3; i++) begin
         x = d_in[16*i +: 16];
         m = mean_ff[16*i +: 16];
         dv[i] = $signed({48'd0, m}) - $signed({48'd0, x});
         if (t1_ff && i == 2) begin
            if (x > bound_ff) g = 1'b0;
         end else if (x < m) begin
            g = 1'b0;
         end
      end
      q = 0;
      for (int i = 0; i < 3; i++) begin
         q += coef_at(diag_ff, i) * (dv[i] * dv[i]);
         for (int j = i + 1; j < 3; j++)
            q += 2 * coef_at(offdiag_ff, i + j - 1) * (dv[i] * dv[j]);
      end
      dist_v = (q <= 0) ? 64'd0 : (64'(q) >> shift_ff);
      if (dist_v > 64'hFF_FFFF_FFFF) dist_v = 64'hFF_FFFF_FFFF;
      sc = 0;
      if (g) begin
         sc = (64'(root_of(dist_v[39:0])) * 64'(d_in[48 +: 17])) >> 16;
         if (sc > 64'hF_FFFF) sc = 64'hF_FFFF;
      end
      res.dist_sq = dist_v[39:0];
      res.score   = sc[19:0];
      res.gate    = g;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   assign pending_count = expected_scores.size();

   always @(posedge clock) begin
      score_type e;
      if (reset) begin
         fail_count = 0;
         mean_ff <= '0;
         diag_ff <= '0;
         offdiag_ff <= '0;
         shift_ff <= SHIFT_RESET;
         bound_ff <= BOUND_RESET;
         t1_ff <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_scores.insert(expected_scores.size(), predict_score(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_scores.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, 0);
            end else begin
               e = expected_scores.pop_front();
               if (rsp_tdata[39:0] !== e.dist_sq)
                  report_mismatch("distance_sq", rsp_tdata[39:0], e.dist_sq);
               if (rsp_tdata[59:40] !== e.score)
                  report_mismatch("score", rsp_tdata[59:40], e.score);
               if (rsp_tdata[60] !== e.gate)
                  report_mismatch("gate_passed", rsp_tdata[60], e.gate);
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_MEAN:    mean_ff <= csr_wdata[47:0];
               REG_DIAG:    diag_ff <= csr_wdata;
               REG_OFFDIAG: offdiag_ff <= csr_wdata;
               REG_SHIFT:   shift_ff <= csr_wdata[5:0];
               REG_BOUND:   bound_ff <= csr_wdata[15:0];
               REG_T1:      t1_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mahalanobis outlier score testbench
// Drives voxels and register settings into the block with random gaps and
// stalls on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
   import mos_pkg::*;

   localparam int PHASES = 8;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [71:0]      req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [63:0]      rsp_tdata;
   logic             csr_we;
   logic [IDX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_wdata;
   int               fail_count;
   int               pending_count;
   bit               long_hold;

   mahalanobis_outlier_score dut (.*);

   mos_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("FAILED: results differ");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off while the sender streams.
   initial begin
      int wait_n;
      rsp_tready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (200) @(posedge clock);
            long_hold = 0;
         end
         wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         if (wait_n > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock iff rsp_tvalid);
      end
   end

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_voxel(input logic [15:0] c0, input logic [15:0] c1,
                             input logic [15:0] c2, input logic [16:0] pw, input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 12) : 0;
      if (gaps && $urandom_range(0, 2) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, pw, c2, c1, c0};
      @(posedge clock iff req_tready);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock iff pending_count == 0);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [15:0] near(input logic [15:0] m);
      int v;
      v = int'(m) + $urandom_range(0, 600) - 300;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   function automatic logic [53:0] rand_coefs(input int mode);
      logic [53:0] v;
      for (int i = 0; i < 3; i++) begin
         case (mode)
            0: v[18*i +: 18] = 18'h1FFFF;
            1: v[18*i +: 18] = 18'h20000;
            2: v[18*i +: 18] = $urandom_range(0, 4000);
            default: v[18*i +: 18] = $urandom;
         endcase
      end
      return v;
   endfunction

   initial begin
      logic [47:0] means;
      logic [16:0] pw;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      long_hold = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset registers, then extremes.
      send_voxel(16'h0000, 16'h0000, 16'h0000, 17'h10000, 0);
      send_voxel(16'hFFFF, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 0);
      drain();
      write_reg(REG_MEAN, 48'h8000_8000_8000);
      write_reg(REG_DIAG, rand_coefs(0));
      write_reg(REG_OFFDIAG, '0);
      write_reg(REG_SHIFT, 6'd0);
      write_reg(3'd7, '1);
      send_voxel(16'hFFFF, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 0);
      send_voxel(16'h0000, 16'h0000, 16'h0000, 17'h1FFFF, 0);
      send_voxel(16'h8000, 16'h8000, 16'h8000, 17'h10000, 0);
      send_voxel(16'h8001, 16'h8000, 16'h7FFF, 17'h0, 0);
      drain();
      write_reg(REG_DIAG, rand_coefs(1));
      write_reg(REG_OFFDIAG, rand_coefs(0));
      write_reg(REG_SHIFT, 6'd63);
      write_reg(REG_T1, 54'd1);
      write_reg(REG_BOUND, 54'd0);
      send_voxel(16'hFFFF, 16'hFFFF, 16'h0000, 17'h10000, 0);
      send_voxel(16'hFFFF, 16'hFFFF, 16'h0001, 17'h10000, 0);
      drain();
      write_reg(REG_SHIFT, 6'd20);
      write_reg(REG_DIAG, rand_coefs(0));
      write_reg(REG_OFFDIAG, rand_coefs(1));
      send_voxel(16'hFFFF, 16'h0000, 16'hFFFF, 17'h10000, 0);
      send_voxel(16'hFFFF, 16'hFFFF, 16'h8000, 17'h1FFFF, 0);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         means = {16'($urandom), 16'($urandom), 16'($urandom)};
         if (ph == 1) means = '1;
         write_reg(REG_MEAN, means);
         write_reg(REG_DIAG, rand_coefs(ph % 4));
         write_reg(REG_OFFDIAG, rand_coefs((ph + 2) % 4));
         write_reg(REG_SHIFT, (ph == 3) ? 6'd0 : (ph == 5 ? 6'd63 : 6'($urandom_range(0, 40))));
         write_reg(REG_BOUND, (ph == 2) ? 16'hFFFF : 16'($urandom));
         write_reg(REG_T1, ph % 2);
         if (ph == 4) long_hold = 1;
         for (int k = 0; k < 225; k++) begin
            pw = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
            if ($urandom_range(0, 3) == 0)
               send_voxel($urandom, $urandom, $urandom, pw, ph != 4);
            else
               send_voxel(near(means[15:0]), near(means[31:16]), near(means[47:32]),
                          pw, ph != 4);
         end
         drain();
      end

      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- mahalanobis_outlier_score.f -----
sv/mos_pkg.sv
sv/mos_lane.sv
sv/mos_merge.sv
sv/mos_sqrt.sv
sv/mahalanobis_outlier_score.sv
verif/mos_checker.sv
verif/tb.sv
